// ----- sv/tlc_pkg.sv -----
package tlc_pkg;

   localparam int L1_SETS_LOG2 = 8;
   localparam int L1_MAX_SETS = 1 << L1_SETS_LOG2;
   localparam int L1_MAX_WAYS = 4;
   localparam int L1_WAY_BITS = 2;
   localparam int L2_SETS_LOG2 = 10;
   localparam int L2_MAX_SETS = 1 << L2_SETS_LOG2;
   localparam int L2_MAX_WAYS = 8;
   localparam int L2_WAY_BITS = 3;
   localparam int TAG_BITS = 32;
   localparam int CLR_BITS = L2_SETS_LOG2 + 1;

   localparam logic [2:0] CSR_L1_OFFSET = 3'd0;
   localparam logic [2:0] CSR_L1_INDEX = 3'd1;
   localparam logic [2:0] CSR_L1_WAYS = 3'd2;
   localparam logic [2:0] CSR_L2_OFFSET = 3'd3;
   localparam logic [2:0] CSR_L2_INDEX = 3'd4;
   localparam logic [2:0] CSR_L2_WAYS = 3'd5;

   typedef enum logic [2:0] {
      RES_NONE = 3'd0,
      RES_RD_HIT = 3'd1,
      RES_RD_MISS = 3'd2,
      RES_WR_HIT = 3'd3,
      RES_WR_MISS = 3'd4
   } res_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_L1_RD,
      ST_L1_CMP,
      ST_L2_RD,
      ST_L2_CMP,
      ST_WB_RD,
      ST_WB_CMP,
      ST_L1_FILL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [L1_WAY_BITS-1:0] ptr;
      logic [L1_MAX_WAYS-1:0] valid;
      logic [L1_MAX_WAYS-1:0] dirty;
      logic [L1_MAX_WAYS-1:0][TAG_BITS-1:0] tags;
   } l1_row_type;

   typedef struct packed {
      logic [L2_WAY_BITS-1:0] ptr;
      logic [L2_MAX_WAYS-1:0] valid;
      logic [L2_MAX_WAYS-1:0] dirty;
      logic [L2_MAX_WAYS-1:0][TAG_BITS-1:0] tags;
   } l2_row_type;

   typedef struct packed {
      logic clear;
      logic load_req;
      logic l1_read;
      logic l1_eval;
      logic l2_read;
      logic wb_sel;
      logic l2_eval;
      logic wb_eval;
      logic l1_fill;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic is_write;
      logic l1_hit;
      logic victim_dirty;
      logic rsp_free;
   } status_type;

   function automatic logic [31:0] index_field(input logic [31:0] addr,
                                               input logic [3:0] off,
                                               input logic [3:0] idx);
      index_field = (addr >> off) & ((32'd1 << idx) - 32'd1);
   endfunction

   function automatic logic [31:0] tag_field(input logic [31:0] addr,
                                             input logic [3:0] off,
                                             input logic [3:0] idx);
      tag_field = addr >> ({1'b0, off} + {1'b0, idx});
   endfunction

endpackage

// ----- sv/tlc_ram.sv -----
module tlc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/tlc_datapath.sv -----
module tlc_datapath
   import tlc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       req_opcode,
   input  logic [31:0] req_address,
   input  logic       csr_valid,
   input  logic [2:0] csr_index,
   input  logic [3:0] csr_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output res_type    rsp_l1,
   output res_type    rsp_l2
);

   logic [3:0] off1_ff, idx1_ff, off2_ff, idx2_ff, ways2_ff;
   logic [2:0] ways1_ff;
   logic op_ff;
   logic [31:0] addr_ff;
   logic [CLR_BITS-1:0] clr_cnt_ff;
   res_type r1_ff, r1_in, r2_ff, r2_in;
   logic rsp_valid_ff;
   res_type rsp_l1_ff, rsp_l2_ff;
   logic [L2_SETS_LOG2-1:0] l2_set_ff, l2_set_in;
   logic [31:0] l2_tag_ff, l2_tag_in;

   logic [31:0] raw1, tag1, ev, l2_lk_addr, l2_idx_full;
   logic [4:0] sh1;
   logic [2:0] w1c;
   logic [3:0] w2c;
   l1_row_type l1_row, l1_wr_row;
   l2_row_type l2_row, l2_wr_row;
   logic l1_wr, l2_wr, hit1, hit2;
   logic [L1_WAY_BITS-1:0] hw1, v1, n1;
   logic [L2_WAY_BITS-1:0] hw2, v2, n2;

   always_ff @(posedge clock) begin
      if (reset) begin
         off1_ff <= 4'd5;
         idx1_ff <= 4'd6;
         ways1_ff <= 3'd4;
         off2_ff <= 4'd6;
         idx2_ff <= 4'd9;
         ways2_ff <= 4'd8;
         clr_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_L1_OFFSET: off1_ff <= csr_data;
               CSR_L1_INDEX: idx1_ff <= csr_data;
               CSR_L1_WAYS: ways1_ff <= csr_data[2:0];
               CSR_L2_OFFSET: off2_ff <= csr_data;
               CSR_L2_INDEX: idx2_ff <= csr_data;
               CSR_L2_WAYS: ways2_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.clear) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff <= req_opcode;
         addr_ff <= req_address;
      end
      if (cmd.l2_read) begin
         l2_set_ff <= l2_set_in;
         l2_tag_ff <= l2_tag_in;
      end
      r1_ff <= r1_in;
      r2_ff <= r2_in;
      if (cmd.rsp_load) begin
         rsp_l1_ff <= r1_ff;
         rsp_l2_ff <= r2_ff;
      end
   end

   always_comb begin
      raw1 = index_field(addr_ff, off1_ff, idx1_ff);
      tag1 = tag_field(addr_ff, off1_ff, idx1_ff);
      sh1 = {1'b0, off1_ff} + {1'b0, idx1_ff};
      w1c = (ways1_ff == 3'd0) ? 3'd1 : (ways1_ff > 3'(L1_MAX_WAYS)) ? 3'(L1_MAX_WAYS) : ways1_ff;
      w2c = (ways2_ff == 4'd0) ? 4'd1 : (ways2_ff > 4'(L2_MAX_WAYS)) ? 4'(L2_MAX_WAYS) : ways2_ff;

      hit1 = 1'b0;
      hw1 = '0;
      for (int w = L1_MAX_WAYS - 1; w >= 0; w--) begin
         if (3'(w) < w1c && l1_row.valid[w] && l1_row.tags[w] == tag1) begin
            hit1 = 1'b1;
            hw1 = L1_WAY_BITS'(w);
         end
      end
      v1 = ({1'b0, l1_row.ptr} < w1c) ? l1_row.ptr : '0;
      n1 = ({1'b0, v1} + 3'd1 < w1c) ? v1 + 1'b1 : '0;

      hit2 = 1'b0;
      hw2 = '0;
      for (int w = L2_MAX_WAYS - 1; w >= 0; w--) begin
         if (4'(w) < w2c && l2_row.valid[w] && l2_row.tags[w] == l2_tag_ff) begin
            hit2 = 1'b1;
            hw2 = L2_WAY_BITS'(w);
         end
      end
      v2 = ({1'b0, l2_row.ptr} < w2c) ? l2_row.ptr : '0;
      n2 = ({1'b0, v2} + 4'd1 < w2c) ? v2 + 1'b1 : '0;

      ev = (l1_row.tags[v1] << sh1) | (raw1 << off1_ff)
         | (addr_ff & ((32'd1 << off1_ff) - 32'd1));
      l2_lk_addr = cmd.wb_sel ? ev : addr_ff;
      l2_idx_full = index_field(l2_lk_addr, off2_ff, idx2_ff);
      l2_set_in = l2_idx_full[L2_SETS_LOG2-1:0];
      l2_tag_in = tag_field(l2_lk_addr, off2_ff, idx2_ff);

      r1_in = r1_ff;
      r2_in = r2_ff;
      if (cmd.l1_eval) begin
         r1_in = hit1 ? (op_ff ? RES_WR_HIT : RES_RD_HIT) : (op_ff ? RES_WR_MISS : RES_RD_MISS);
         r2_in = RES_NONE;
      end
      if (cmd.l2_eval) begin
         r2_in = hit2 ? (op_ff ? RES_WR_HIT : RES_RD_HIT) : (op_ff ? RES_WR_MISS : RES_RD_MISS);
      end

      l1_wr_row = l1_row;
      l1_wr = 1'b0;
      if (cmd.clear) begin
         l1_wr_row = '0;
         l1_wr = 1'b1;
      end else if (cmd.l1_eval && hit1 && op_ff) begin
         l1_wr_row.dirty[hw1] = 1'b1;
         l1_wr = 1'b1;
      end else if (cmd.l1_fill) begin
         l1_wr_row.tags[v1] = tag1;
         l1_wr_row.valid[v1] = 1'b1;
         l1_wr_row.dirty[v1] = 1'b0;
         l1_wr_row.ptr = n1;
         l1_wr = 1'b1;
      end

      l2_wr_row = l2_row;
      l2_wr = 1'b0;
      if (cmd.clear) begin
         l2_wr_row = '0;
         l2_wr = 1'b1;
      end else if ((cmd.l2_eval || cmd.wb_eval) && hit2) begin
         if (op_ff || cmd.wb_eval) begin
            l2_wr_row.dirty[hw2] = 1'b1;
            l2_wr = 1'b1;
         end
      end else if (cmd.l2_eval && !op_ff) begin
         l2_wr_row.tags[v2] = l2_tag_ff;
         l2_wr_row.valid[v2] = 1'b1;
         l2_wr_row.dirty[v2] = 1'b0;
         l2_wr_row.ptr = n2;
         l2_wr = 1'b1;
      end
   end

   tlc_ram #(
      .WIDTH($bits(l1_row_type)),
      .DEPTH(L1_MAX_SETS)
   ) u_l1_ram (
      .clock  (clock),
      .wr_en  (l1_wr),
      .wr_addr(cmd.clear ? clr_cnt_ff[L1_SETS_LOG2-1:0] : raw1[L1_SETS_LOG2-1:0]),
      .wr_data(l1_wr_row),
      .rd_en  (cmd.l1_read),
      .rd_addr(raw1[L1_SETS_LOG2-1:0]),
      .rd_data(l1_row)
   );

   tlc_ram #(
      .WIDTH($bits(l2_row_type)),
      .DEPTH(L2_MAX_SETS)
   ) u_l2_ram (
      .clock  (clock),
      .wr_en  (l2_wr),
      .wr_addr(cmd.clear ? clr_cnt_ff[L2_SETS_LOG2-1:0] : l2_set_ff),
      .wr_data(l2_wr_row),
      .rd_en  (cmd.l2_read),
      .rd_addr(l2_set_in),
      .rd_data(l2_row)
   );

   assign status.clear_done = clr_cnt_ff[CLR_BITS-1];
   assign status.is_write = op_ff;
   assign status.l1_hit = hit1;
   assign status.victim_dirty = l1_row.valid[v1] && l1_row.dirty[v1];
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_l1 = rsp_l1_ff;
   assign rsp_l2 = rsp_l2_ff;

   a_wr_hit_code: assert property (@(posedge clock) disable iff (reset)
      cmd.l1_eval && hit1 && op_ff |=> r1_ff == RES_WR_HIT)
      else $error("L1 write hit did not record a write hit code.");

   a_l1_hit_skips_l2: assert property (@(posedge clock) disable iff (reset)
      cmd.l1_eval && hit1 |=> r2_ff == RES_NONE)
      else $error("L2 code set although L1 hit.");

endmodule

// ----- sv/tlc_ctrl.sv -----
module tlc_ctrl
   import tlc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (status.clear_done) state_in = ST_IDLE;
         ST_IDLE: if (req_valid) state_in = ST_L1_RD;
         ST_L1_RD: state_in = ST_L1_CMP;
         ST_L1_CMP: state_in = status.l1_hit ? ST_FINISH : ST_L2_RD;
         ST_L2_RD: state_in = ST_L2_CMP;
         ST_L2_CMP: begin
            priority if (status.is_write) state_in = ST_FINISH;
            else if (status.victim_dirty) state_in = ST_WB_RD;
            else state_in = ST_L1_FILL;
         end
         ST_WB_RD: state_in = ST_WB_CMP;
         ST_WB_CMP: state_in = ST_L1_FILL;
         ST_L1_FILL: state_in = ST_FINISH;
         ST_FINISH: if (status.rsp_free) state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear = !status.clear_done;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_L1_RD: cmd.l1_read = 1'b1;
         ST_L1_CMP: cmd.l1_eval = 1'b1;
         ST_L2_RD: cmd.l2_read = 1'b1;
         ST_L2_CMP: cmd.l2_eval = 1'b1;
         ST_WB_RD: begin
            cmd.l2_read = 1'b1;
            cmd.wb_sel = 1'b1;
         end
         ST_WB_CMP: cmd.wb_eval = 1'b1;
         ST_L1_FILL: cmd.l1_fill = 1'b1;
         ST_FINISH: cmd.rsp_load = status.rsp_free;
         default: ;
      endcase
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_L1_RD)
      else $error("Accepted request did not start an L1 lookup.");

   a_wb_only_dirty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WB_RD |-> $past(status.victim_dirty) && !$past(status.is_write))
      else $error("Write-back lookup without a dirty victim.");

endmodule

// ----- sv/two_level_cache_tag_controller.sv -----
// Tag controller for a two-level set-associative cache with round-robin
// replacement, write-back and write-no-allocate.
// Requests arrive on the req_ stream: req_tuser carries the opcode (0 read,
// 1 write) and req_tdata the 32-bit byte address. Each request yields exactly
// one response on the rsp_ stream, carrying the L1 and L2 outcome codes.
// The geometry registers are written through the csr_ port, which is always
// ready; they may change only while no request is in flight.
// A request does an L1 tag read and compare and responds on a hit. A miss
// adds an L2 read and compare; a write then responds, and a read fills L1,
// after an L2 write-back lookup if the victim is dirty. Each lookup costs a
// registered read of the set's tag row and each update a write of it, and
// only one request is in flight at a time. After reset the block clears both
// tag memories, one set per cycle, with req_tready low; configuration writes
// are taken meanwhile. When the receiver stalls, one finished response waits
// in the output register and a new request is still accepted; that request
// then waits before its own response until the register drains.
module two_level_cache_tag_controller
   import tlc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // address
   input  logic [0:0]  req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // l1_result, l2_result, zero fill
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [3:0]  csr_data
);

   cmd_type cmd;
   status_type status;
   res_type rsp_l1, rsp_l2;

   tlc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   tlc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_opcode (req_tuser[0]),
      .req_address(req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_l1     (rsp_l1),
      .rsp_l2     (rsp_l2)
   );

   assign csr_ready = 1'b1;
   assign rsp_tdata = {2'b00, rsp_l2, rsp_l1};

endmodule
